// ----- design/fwmtf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fwmtf_pkg
// Shared types and codes for the FIFO with move-to-front request.
// ----------------------------------------------------------------------------
package fwmtf_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int DATA_W = 32;
	localparam int ACT_W  = 2;
	localparam int POS_W  = 5;
	localparam int STS_W  = 2;
	localparam int OCC_W  = 5;

	// request actions
	localparam logic [ACT_W-1:0] ACT_ENQ  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DEQ  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_MOVE = 2'd2;

	// result status codes
	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd2;
	localparam logic [STS_W-1:0] STS_RANGE = 2'd3;

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] head_value;
		logic [STS_W-1:0]         status;
		logic [OCC_W-1:0]         occupancy;
	} rsp_t;

endpackage
`default_nettype wire

// ----- design/fifo_with_move_to_front_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_with_move_to_front_core
// Bounded FIFO of signed words with enqueue, dequeue and move-to-front.
// ----------------------------------------------------------------------------
// One request is taken at a time and answered by exactly one result word.
// Enqueue, and every request that is flagged or changes nothing, goes
// from acceptance straight to its result; dequeue first reads the head
// entry; a move of the entry at position p (p of 2 or more) saves it,
// shifts the entries ahead of it back one per cycle through the entry
// store, which has one read port and one write port, then writes it at
// the head. A finished result sits in an output register, so the next
// request is accepted while it waits; a second result stalls only until
// the first is taken. The entry store needs no clearing after reset.
// ----------------------------------------------------------------------------
module fifo_with_move_to_front_core
	import fwmtf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;
	logic              ctl_valid, ctl_take;
	rsp_t              ctl_rsp;
	logic              out_valid_q;
	rsp_t              out_q;

	fwmtf_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (ctl_valid),
		.rsp_take  (ctl_take),
		.rsp       (ctl_rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	fwmtf_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// load the output register when it is empty or being drained
	assign ctl_take = ctl_valid && (!out_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_take) begin
			out_q <= ctl_rsp;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

// ----- design/fwmtf_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fwmtf_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fwmtf_ram
	import fwmtf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read word, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- design/fwmtf_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fwmtf_ctrl
// Request sequencer: keeps head pointer and count over a circular entry
// store and steps enqueue, dequeue and move-to-front through
// wrap-around address adders, one memory access pair per cycle.
// ----------------------------------------------------------------------------
module fwmtf_ctrl
	import fwmtf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request side
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_t              req,
	// result side
	output logic                   rsp_valid,
	input  wire logic              rsp_take,
	output rsp_t                   rsp,
	// entry store
	output logic                   mem_we,
	output logic      [AW-1:0]     mem_waddr,
	output logic      [DATA_W-1:0] mem_wdata,
	output logic                   mem_re,
	output logic      [AW-1:0]     mem_raddr,
	input  wire logic [DATA_W-1:0] mem_rdata
);

	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DEQ     = 3'd1;
	localparam logic [2:0] S_MVSAVE  = 3'd2;
	localparam logic [2:0] S_MVSHIFT = 3'd3;
	localparam logic [2:0] S_MVHEAD  = 3'd4;
	localparam logic [2:0] S_DONE    = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [AW-1:0]     head_q, head_d;
	logic [CW-1:0]     count_q, count_d;
	logic [AW-1:0]     k_q, k_d;
	logic [DATA_W-1:0] moved_q, moved_d;
	logic [DATA_W-1:0] hv_q, hv_d;
	logic [STS_W-1:0]  sts_q, sts_d;

	logic              fire;
	logic [AW-1:0]     rd_off, wr_off;
	logic [CMPW-1:0]   pos_ext, cnt_ext;
	logic              full, empty;

	// Offset from base, wrapped around the store depth.
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign fire      = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign pos_ext   = CMPW'(req.position);
	assign cnt_ext   = CMPW'(count_q);
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);

	// address units: read and write offsets from the head
	assign mem_raddr = wrap_add(head_q, rd_off);
	assign mem_waddr = wrap_add(head_q, wr_off);

	// sequence the request
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		k_d       = k_q;
		moved_d   = moved_q;
		hv_d      = hv_q;
		sts_d     = sts_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = mem_rdata;
		rd_off    = '0;
		wr_off    = '0;
		case (state_q)
			S_IDLE: begin
				if (fire) begin
					hv_d    = '0;
					sts_d   = STS_OK;
					state_d = S_DONE;
					case (req.action)
						ACT_ENQ: begin
							if (full) begin
								sts_d = STS_FULL;
							end else begin
								mem_we    = 1'b1;
								wr_off    = AW'(count_q);
								mem_wdata = req.value;
								count_d   = count_q + CW'(1);
							end
						end
						ACT_DEQ: begin
							if (empty) begin
								sts_d = STS_EMPTY;
							end else begin
								mem_re  = 1'b1;
								state_d = S_DEQ;
							end
						end
						ACT_MOVE: begin
							if (pos_ext == '0 || pos_ext > cnt_ext) begin
								sts_d = STS_RANGE;
							end else if (pos_ext != CMPW'(1)) begin
								// fetch the entry that goes to the front
								mem_re  = 1'b1;
								rd_off  = AW'(pos_ext - CMPW'(1));
								k_d     = AW'(pos_ext - CMPW'(1));
								state_d = S_MVSAVE;
							end
						end
						default: begin
							sts_d = STS_OK;
						end
					endcase
				end
			end
			S_DEQ: begin
				hv_d    = mem_rdata;
				head_d  = wrap_add(head_q, AW'(1));
				count_d = count_q - CW'(1);
				state_d = S_DONE;
			end
			S_MVSAVE: begin
				moved_d = mem_rdata;
				mem_re  = 1'b1;
				rd_off  = k_q - AW'(1);
				state_d = S_MVSHIFT;
			end
			S_MVSHIFT: begin
				// push one entry back toward the tail, fetch the next one
				mem_we    = 1'b1;
				wr_off    = k_q;
				mem_wdata = mem_rdata;
				k_d       = k_q - AW'(1);
				if (k_q == AW'(1)) begin
					state_d = S_MVHEAD;
				end else begin
					mem_re = 1'b1;
					rd_off = k_q - AW'(2);
				end
			end
			S_MVHEAD: begin
				mem_we    = 1'b1;
				wr_off    = '0;
				mem_wdata = moved_q;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (rsp_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		k_q     <= k_d;
		moved_q <= moved_d;
		hv_q    <= hv_d;
		sts_q   <= sts_d;
	end

	assign rsp_valid      = (state_q == S_DONE);
	assign rsp.head_value = hv_q;
	assign rsp.status     = sts_q;
	assign rsp.occupancy  = OCC_W'(count_q);

	// count stays within the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count exceeds depth");

	// accepted enqueue into a non-full queue grows the count by one
	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req.action == ACT_ENQ && !full) |=> count_q == $past(count_q) + CW'(1))
		else $error("enqueue did not advance count");

	// move sequence never changes count or head
	a_move_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MVSAVE || state_q == S_MVSHIFT || state_q == S_MVHEAD)
		|=> $stable(count_q) && $stable(head_q))
		else $error("move altered count or head");

	// store is written only by an enqueue or a move step
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (fire && req.action == ACT_ENQ) || state_q == S_MVSHIFT
		|| state_q == S_MVHEAD)
		else $error("unexpected store write");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FIFO with move-to-front request.
// ----------------------------------------------------------------------------
// Requests go in over a valid/ready channel. A scoreboard keeps its own copy
// of the queue and predicts one result word per accepted request. Results
// are compared field by field in order. A short directed run hits underflow,
// overflow, out-of-range moves, tail moves and the spare action code. Random
// traffic then drifts the fill level up and down with mixed moves. Idling
// on each side is varied across three phases.
// ----------------------------------------------------------------------------
module testbench;
	import fwmtf_pkg::*;

	// action code that the block takes as a no-op
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
	localparam int ITEMS_PER_PHASE = 460;
	localparam int DRIFT_RUN = 60;
	localparam int DRAIN_CYCLES = 25;

	// Track the queue contents and the result words still owed.
	class mtf_queue_tracker;
		logic signed [DATA_W-1:0] held[$];
		rsp_t owed[$];
		int unsigned mismatches = 0;
		int unsigned requests_seen = 0;
		int unsigned results_seen = 0;
		int unsigned reorders = 0;
		int unsigned deepest = 0;
		int unsigned status_seen[4] = '{0, 0, 0, 0};

		// Predict the result of one accepted request and advance the queue.
		function void note_request(req_t r);
			rsp_t e;
			logic signed [DATA_W-1:0] w;
			int p;
			e = '0;
			e.status = STS_OK;
			p = r.position;
			case (r.action)
				ACT_ENQ: begin
					if (held.size() >= DEPTH_DEF)
						e.status = STS_FULL;
					else
						held.push_back(r.value);
				end
				ACT_DEQ: begin
					if (held.size() == 0)
						e.status = STS_EMPTY;
					else
						e.head_value = held.pop_front();
				end
				ACT_MOVE: begin
					if (p < 1 || p > held.size()) begin
						e.status = STS_RANGE;
					end else if (p > 1) begin
						w = held[p-1];
						held.delete(p-1);
						held.push_front(w);
						reorders++;
					end
				end
				default: begin
				end
			endcase
			e.occupancy = OCC_W'(held.size());
			if (held.size() > deepest)
				deepest = held.size();
			requests_seen++;
			owed.push_back(e);
		endfunction

		// Compare one accepted result word with the oldest one owed.
		function void check_result(rsp_t got);
			rsp_t e;
			results_seen++;
			if (owed.size() == 0) begin
				$display("%0t: result with none expected: value %0d status %0d occ %0d",
					$time, got.head_value, got.status, got.occupancy);
				mismatches++;
				return;
			end
			e = owed.pop_front();
			status_seen[e.status]++;
			if (got.head_value !== e.head_value) begin
				$display("%0t: head_value expected %0d, got %0d",
					$time, e.head_value, got.head_value);
				mismatches++;
			end
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d, got %0d", $time, e.status, got.status);
				mismatches++;
			end
			if (got.occupancy !== e.occupancy) begin
				$display("%0t: occupancy expected %0d, got %0d",
					$time, e.occupancy, got.occupancy);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	mtf_queue_tracker tracker = new;

	fifo_with_move_to_front_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// 20 ns clock
	always #10 clk = ~clk;

	// Stall the result side at random.
	always @(negedge clk) begin
		rsp_ready = ($urandom_range(99) >= recv_idle_pct);
	end

	// Watch both channels; a result taken on an edge always predates
	// the request taken on that same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				tracker.check_result(rsp);
			if (req_valid && req_ready)
				tracker.note_request(req);
		end
	end

	// Hold one request word until it is taken, after an optional idle gap.
	task automatic send_word(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req = r;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	function automatic req_t pack_req(logic [ACT_W-1:0] a, logic [DATA_W-1:0] v,
		logic [POS_W-1:0] p);
		req_t r;
		r.action = a;
		r.value = v;
		r.position = p;
		return r;
	endfunction

	// Build a random request; the fill level drifts up or down.
	function automatic req_t random_request(bit fill_up);
		req_t r;
		int roll;
		int n;
		n = tracker.held.size();
		r.value = $urandom;
		r.position = POS_W'($urandom_range(31));
		case ($urandom_range(15))
			0: r.value = 32'h7fff_ffff;
			1: r.value = 32'h8000_0000;
			2: r.value = 32'hffff_ffff;
			3: r.value = '0;
			default: begin
			end
		endcase
		roll = $urandom_range(99);
		if (roll < (fill_up ? 50 : 20))
			r.action = ACT_ENQ;
		else if (roll < 70)
			r.action = ACT_DEQ;
		else if (roll < 97)
			r.action = ACT_MOVE;
		else
			r.action = ACT_SPARE;
		// mostly legal positions for moves, a few anywhere
		if (r.action == ACT_MOVE && n > 0 && $urandom_range(7) != 0)
			r.position = POS_W'($urandom_range(n, 1));
		return r;
	endfunction

	// Drain every result owed before moving on.
	task automatic hold_until_drained();
		req_valid = 1'b0;
		while (tracker.owed.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_phase(input int unsigned s_idle, input int unsigned r_idle);
		bit fill_up;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		fill_up = 1'($urandom_range(1));
		for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
			if (i % DRIFT_RUN == 0)
				fill_up = ~fill_up;
			send_word(random_request(fill_up));
		end
		hold_until_drained();
	endtask

	// Main sequence
	initial begin
		send_idle_pct = 9;
		recv_idle_pct = 46;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty-queue corner cases and the spare code
		send_word(pack_req(ACT_DEQ, 32'h1234_5678, 5'd0));
		send_word(pack_req(ACT_MOVE, '0, 5'd1));
		send_word(pack_req(ACT_SPARE, 32'hdead_beef, 5'd31));
		// extreme words, then moves around a two-entry queue
		send_word(pack_req(ACT_ENQ, 32'h7fff_ffff, 5'd0));
		send_word(pack_req(ACT_ENQ, 32'h8000_0000, 5'd31));
		send_word(pack_req(ACT_MOVE, '0, 5'd0));
		send_word(pack_req(ACT_MOVE, '0, 5'd3));
		send_word(pack_req(ACT_MOVE, '0, 5'd2));
		send_word(pack_req(ACT_MOVE, '0, 5'd1));
		send_word(pack_req(ACT_DEQ, '0, 5'd16));
		// fill to the brim, overflow once, move the tail, move out of range, dequeue
		for (int i = 1; i < DEPTH_DEF; i++)
			send_word(pack_req(ACT_ENQ, (i % 2) ? 32'hffff_ffff : 32'h0, 5'd16));
		send_word(pack_req(ACT_ENQ, 32'h5555_aaaa, 5'd0));
		send_word(pack_req(ACT_MOVE, '0, 5'd16));
		send_word(pack_req(ACT_MOVE, '0, 5'd31));
		send_word(pack_req(ACT_DEQ, '0, 5'd0));
		hold_until_drained();

		random_phase(9, 46);
		random_phase(46, 9);
		random_phase(0, 0);

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (tracker.owed.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, tracker.owed.size());
			tracker.mismatches++;
		end
		$display("Ran %0d requests, %0d results: %0d ok, %0d underflow, %0d overflow, %0d range.",
			tracker.requests_seen, tracker.results_seen, tracker.status_seen[STS_OK],
			tracker.status_seen[STS_EMPTY], tracker.status_seen[STS_FULL],
			tracker.status_seen[STS_RANGE]);
		$display("Peak fill %0d of %0d, %0d moves reordered the queue.",
			tracker.deepest, DEPTH_DEF, tracker.reorders);
		if (tracker.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#10ms;
		$display("Timeout with %0d results outstanding", tracker.owed.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
